// ===== sv/gdr_pkg.sv =====
// Package: shared types, constants and GF(2^8) multiply for the share reconstruct core
`timescale 1ns / 1ps
package gdr_pkg;

    localparam logic [8:0] GF_POLY = 9'h171;
    localparam int         CFG_W   = 24;
    localparam int         IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_TAIL = 2'd3;

    typedef logic [8:0][7:0] t_mat;
    typedef logic [2:0][7:0] t_trip;

    typedef struct packed {
        logic busy;
        logic singular;
    } t_inv_stat;

    localparam t_mat MAT_IDENT = {8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1};

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) r = r ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ GF_POLY;
        end
        return r;
    endfunction

endpackage

// ===== sv/gdr_if.sv =====
// Interfaces: share triple request channel and reconstructed triple channel
`timescale 1ns / 1ps
interface gdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] share0_byte;
    logic [7:0] share1_byte;
    logic [7:0] share2_byte;
    logic       last_item;
    modport source (output valid, share0_byte, share1_byte, share2_byte, last_item,
                    input ready);
    modport sink   (input valid, share0_byte, share1_byte, share2_byte, last_item,
                    output ready);
endinterface

interface gdr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [1:0] valid_count;
    logic       singular;
    logic       final_out;
    modport source (output valid, out_byte0, out_byte1, out_byte2, valid_count, singular,
                    final_out, input ready);
    modport sink   (input valid, out_byte0, out_byte1, out_byte2, valid_count, singular,
                    final_out, output ready);
endinterface

// ===== sv/gf256_dispersal_reconstruct_core.sv =====
// Top level: config registers, stream state, inverse unit and reconstruct pipeline
//  channel   dir   handshake       payload
//  i_src     in    valid/ready     share0..2_byte, last_item
//  o_dst     out   valid/ready     out_byte0..2, valid_count, singular, final_out
//  cfg       in    i_cfg_we        i_cfg_idx, i_cfg_data
// One triple per cycle unless stalled; it passes the product, sum and output stages.
// A coefficient write starts an inversion; a stream start waits for it to finish.
// Reset loads the identity inverse; no clearing pass.
// A stall at the output backs up through the stages without dropping a request.
`timescale 1ns / 1ps
module gf256_dispersal_reconstruct_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    gdr_in_if.sink                    i_src,
    gdr_out_if.source                 o_dst,
    input  logic                      i_cfg_we,
    input  logic [gdr_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [gdr_pkg::CFG_W-1:0] i_cfg_data
);
    import gdr_pkg::*;

    t_trip      r_row0, r_row1, r_row2;
    logic [1:0] r_tail;
    logic       r_in_stream;
    t_mat       r_inv;
    logic       r_sing;
    t_mat       cand_inv;
    t_inv_stat  stat;
    logic       start, dp_rdy, acc;
    t_mat       mat_sel;
    logic       sing_sel;
    logic [1:0] vcnt;
    t_trip      dp_bytes;

    assign start = i_cfg_we && (i_cfg_idx == REG_ROW0 || i_cfg_idx == REG_ROW1
                                || i_cfg_idx == REG_ROW2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= 24'h010000;
            r_row1 <= 24'h000100;
            r_row2 <= 24'h000001;
            r_tail <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW0: r_row0 <= i_cfg_data;
                REG_ROW1: r_row1 <= i_cfg_data;
                REG_ROW2: r_row2 <= i_cfg_data;
                REG_TAIL: r_tail <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    gdr_inv_unit u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_row0  (r_row0),
        .i_row1  (r_row1),
        .i_row2  (r_row2),
        .o_inv   (cand_inv),
        .o_stat  (stat)
    );

    assign i_src.ready = dp_rdy && (r_in_stream || (!stat.busy && !start));
    assign acc         = i_src.valid && i_src.ready;
    assign mat_sel     = r_in_stream ? r_inv : cand_inv;
    assign sing_sel    = r_in_stream ? r_sing : stat.singular;
    assign vcnt        = (i_src.last_item && (r_tail == 2'd1 || r_tail == 2'd2))
                         ? r_tail : 2'd3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stream <= 1'b0;
            r_inv       <= MAT_IDENT;
            r_sing      <= 1'b0;
        end else if (acc) begin
            r_in_stream <= !i_src.last_item;
            if (!r_in_stream) begin
                r_inv  <= cand_inv;
                r_sing <= stat.singular;
            end
        end
    end

    gdr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .o_rdy   (dp_rdy),
        .i_mat   (mat_sel),
        .i_sing  (sing_sel),
        .i_data  ({i_src.share2_byte, i_src.share1_byte, i_src.share0_byte}),
        .i_last  (i_src.last_item),
        .i_vcnt  (vcnt),
        .o_valid (o_dst.valid),
        .i_ready (o_dst.ready),
        .o_bytes (dp_bytes),
        .o_vcnt  (o_dst.valid_count),
        .o_sing  (o_dst.singular),
        .o_last  (o_dst.final_out)
    );

    assign o_dst.out_byte0 = dp_bytes[0];
    assign o_dst.out_byte1 = dp_bytes[1];
    assign o_dst.out_byte2 = dp_bytes[2];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !r_in_stream) |-> !stat.busy) else $error("stream start during inversion");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_src.last_item) |=> !r_in_stream) else $error("stream not closed");
endmodule

// ===== sv/gdr_inv_unit.sv =====
// Matrix inverse sequencer: cofactors, determinant, x^254 reciprocal, scaled adjugate
`timescale 1ns / 1ps
module gdr_inv_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gdr_pkg::t_trip      i_row0,
    input  gdr_pkg::t_trip      i_row1,
    input  gdr_pkg::t_trip      i_row2,
    output gdr_pkg::t_mat       o_inv,
    output gdr_pkg::t_inv_stat  o_stat
);
    import gdr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COF  = 3'd1;
    localparam logic [2:0] S_DET  = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [7:0] EXP_E  = 8'd254;

    logic [2:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    t_mat       r_cof, n_cof;
    logic [7:0] r_det, n_det;
    logic [7:0] r_res, n_res;
    logic [7:0] r_base, n_base;
    t_mat       r_inv, n_inv;
    logic       r_sing, n_sing;
    logic [2:0][2:0][7:0] m;

    always_comb begin
        m[0] = i_row0;
        m[1] = i_row1;
        m[2] = i_row2;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_cof   = r_cof;
        n_det   = r_det;
        n_res   = r_res;
        n_base  = r_base;
        n_inv   = r_inv;
        n_sing  = r_sing;
        unique case (r_state)
            S_IDLE: ;
            S_COF: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_cof[i*3+j] = gf_mul(m[(i+1)%3][2-((j+1)%3)], m[(i+2)%3][2-((j+2)%3)])
                                     ^ gf_mul(m[(i+1)%3][2-((j+2)%3)], m[(i+2)%3][2-((j+1)%3)]);
                    end
                end
                n_state = S_DET;
            end
            S_DET: begin
                n_det = gf_mul(m[0][2], r_cof[0]) ^ gf_mul(m[0][1], r_cof[1])
                      ^ gf_mul(m[0][0], r_cof[2]);
                n_res   = 8'd1;
                n_base  = n_det;
                n_cnt   = '0;
                n_state = S_EXP;
            end
            S_EXP: begin
                if (EXP_E[r_cnt]) n_res = gf_mul(r_res, r_base);
                n_base = gf_mul(r_base, r_base);
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == 3'd7) n_state = S_FIN;
            end
            S_FIN: begin
                n_sing = (r_det == 8'd0);
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        n_inv[j*3+i] = (r_det == 8'd0) ? 8'd0 : gf_mul(r_cof[i*3+j], r_res);
                    end
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_start) n_state = S_COF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_inv   <= MAT_IDENT;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inv   <= n_inv;
            r_sing  <= n_sing;
        end
        r_cnt  <= n_cnt;
        r_cof  <= n_cof;
        r_det  <= n_det;
        r_res  <= n_res;
        r_base <= n_base;
    end

    assign o_inv           = r_inv;
    assign o_stat.busy     = (r_state != S_IDLE);
    assign o_stat.singular = r_sing;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sing |-> (r_inv == '0)) else $error("singular flag with nonzero inverse");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_stat.busy) else $error("start did not launch inversion");
endmodule

// ===== sv/gdr_datapath.sv =====
// Three-stage reconstruct pipeline: GF products, row sums, output register
`timescale 1ns / 1ps
module gdr_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    output logic           o_rdy,
    input  gdr_pkg::t_mat  i_mat,
    input  logic           i_sing,
    input  gdr_pkg::t_trip i_data,
    input  logic           i_last,
    input  logic [1:0]     i_vcnt,
    output logic           o_valid,
    input  logic           i_ready,
    output gdr_pkg::t_trip o_bytes,
    output logic [1:0]     o_vcnt,
    output logic           o_sing,
    output logic           o_last
);
    import gdr_pkg::*;

    logic       r_v1, r_v2, r_v3;
    logic       rdy1, rdy2, rdy3;
    t_mat       r_prod;
    t_trip      r_sum, r_out;
    logic [3:0] r_f1, r_f2, r_f3;

    assign rdy3  = !r_v3 || i_ready;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign o_rdy = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_acc;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
        if (rdy1 && i_acc) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[i*3+j] <= gf_mul(i_mat[i*3+j], i_data[j]);
                end
            end
            r_f1 <= {i_sing, i_last, i_vcnt};
        end
        if (rdy2 && r_v1) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= r_prod[i*3] ^ r_prod[i*3+1] ^ r_prod[i*3+2];
            end
            r_f2 <= r_f1;
        end
        if (rdy3 && r_v2) begin
            r_out <= r_sum;
            r_f3  <= r_f2;
        end
    end

    assign o_valid = r_v3;
    assign o_bytes = r_out;
    assign o_sing  = r_f3[3];
    assign o_last  = r_f3[2];
    assign o_vcnt  = r_f3[1:0];

    a_vcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_f3[1:0] != 2'd0)) else $error("zero valid count on result");
    a_sing_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_f3[3]) |-> (r_out == '0)) else $error("singular result has data");
endmodule
